[sv/glyph_quad_vertex_builder_unit_assert.svh]
// Assertion macros used by the vertex emitter RTL.
// Each macro expands to one labelled concurrent assertion on the given clock and reset.
`ifndef GLYPH_QUAD_VERTEX_BUILDER_UNIT_ASSERT_SVH
`define GLYPH_QUAD_VERTEX_BUILDER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GQVB_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GQVB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gqvb_pkg.sv]
// Types, constants and helper functions for the glyph quad vertex builder.
// No dependencies; the glyph memory, the emitter, the top level and the testbench import this package.
package gqvb_pkg;

  localparam int TEX_W   = 17;
  localparam int WIDTH_W = 24;
  localparam int POS_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Input actions.
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_PEN  = 2'd1;
  localparam logic [1:0] ACT_DRAW = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 1'b1;

  localparam logic [7:0]         FIRST_CODE  = 8'd32;
  localparam logic [TEX_W-1:0]   TEX_V_STEP  = 17'd6554;
  localparam logic [TEX_W-1:0]   TEX_MAX     = 17'h1FFFF;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 24'hFFFFFF;
  localparam logic [WIDTH_W-1:0] SCALE_RESET = 24'h010000;
  localparam logic [2:0]         LAST_CORNER = 3'd5;

  // Vertex numbers in emission order: TL, BR, BL, TL, TR, BR.
  localparam logic [2:0] C_TL0 = 3'd0;
  localparam logic [2:0] C_BR0 = 3'd1;
  localparam logic [2:0] C_BL  = 3'd2;
  localparam logic [2:0] C_TL1 = 3'd3;
  localparam logic [2:0] C_TR  = 3'd4;
  localparam logic [2:0] C_BR1 = 3'd5;

  // Work held in the read stage.
  typedef enum logic [1:0] {
    OP_PEN   = 2'd0,
    OP_SPACE = 2'd1,
    OP_DRAW  = 2'd2
  } op_t;

  typedef struct packed {
    logic [TEX_W-1:0] left;
    logic [TEX_W-1:0] right;
    logic [TEX_W-1:0] top;
  } tex_entry_t;

  // Everything the emitter needs for the six vertices of one glyph.
  typedef struct packed {
    logic signed [POS_W-1:0] xl;
    logic signed [POS_W-1:0] xr;
    logic signed [POS_W-1:0] yt;
    logic signed [POS_W-1:0] yb;
    logic [TEX_W-1:0]        left;
    logic [TEX_W-1:0]        right;
    logic [TEX_W-1:0]        top;
    logic [TEX_W-1:0]        bottom;
  } quad_t;

  // Pen plus or minus an unsigned width, saturated to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat_step(input logic signed [POS_W-1:0] p,
                                                       input logic [WIDTH_W-1:0] w,
                                                       input logic sub);
    logic signed [POS_W+1:0] ps;
    logic signed [POS_W+1:0] ws;
    logic signed [POS_W+1:0] r;
    ps = $signed({{2{p[POS_W-1]}}, p});
    ws = $signed({{(POS_W+2-WIDTH_W){1'b0}}, w});
    r  = sub ? (ps - ws) : (ps + ws);
    if (r > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (r < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[POS_W-1:0];
  endfunction

  // Texture v at the bottom edge, saturated.
  function automatic logic [TEX_W-1:0] tex_bottom(input logic [TEX_W-1:0] top);
    logic [TEX_W:0] s;
    s = {1'b0, top} + {1'b0, TEX_V_STEP};
    return s[TEX_W] ? TEX_MAX : s[TEX_W-1:0];
  endfunction

endpackage

[sv/gqvb_in_if.sv]
// Input channel of the glyph quad vertex builder: valid/ready plus one item.
// Depends on nothing; widths follow the item fields.
interface gqvb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         char_code;
  logic [6:0]         glyph_index;
  logic [16:0]        tex_left;
  logic [16:0]        tex_right;
  logic [16:0]        tex_top;
  logic [23:0]        raw_width;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;

  modport source (output valid, action, char_code, glyph_index, tex_left, tex_right,
                  tex_top, raw_width, start_x, start_y, input ready);
  modport sink   (input valid, action, char_code, glyph_index, tex_left, tex_right,
                  tex_top, raw_width, start_x, start_y, output ready);
endinterface

[sv/gqvb_out_if.sv]
// Result channel of the glyph quad vertex builder: valid/ready plus one vertex.
// Depends on nothing; widths follow the vertex fields.
interface gqvb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [2:0]         corner;
  logic               last;

  modport source (output valid, pos_x, pos_y, tex_u, tex_v, corner, last, input ready);
  modport sink   (input valid, pos_x, pos_y, tex_u, tex_v, corner, last, output ready);
endinterface

[sv/gqvb_glyph_mem.sv]
// Glyph table storage: texture coordinates and scaled width per entry.
// Uses gqvb_pkg; one write port, one read port with registered read data.
module gqvb_glyph_mem #(
  parameter int GLYPH_COUNT = 95,
  parameter int AW          = 7
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  gqvb_pkg::tex_entry_t         wr_tex,
  input  logic [gqvb_pkg::WIDTH_W-1:0] wr_width,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output gqvb_pkg::tex_entry_t         rd_tex,
  output logic [gqvb_pkg::WIDTH_W-1:0] rd_width
);
  import gqvb_pkg::*;

  tex_entry_t         tex_mem   [GLYPH_COUNT];
  logic [WIDTH_W-1:0] width_mem [GLYPH_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tex_mem[wr_addr]   <= wr_tex;
      width_mem[wr_addr] <= wr_width;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tex   <= tex_mem[rd_addr];
      rd_width <= width_mem[rd_addr];
    end
  end

endmodule

[sv/gqvb_vertex_emit.sv]
// Vertex emitter: holds one glyph quad and sends its six vertices in order.
// Uses gqvb_pkg, gqvb_out_if and the assertion macro header.
module gqvb_vertex_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ld_valid,
  output logic            ld_ready,
  input  gqvb_pkg::quad_t ld_quad,
  gqvb_out_if.source      out_vtx
);
  import gqvb_pkg::*;
  `include "glyph_quad_vertex_builder_unit_assert.svh"

  logic       valid_r, valid_nxt;
  logic [2:0] corner_r, corner_nxt;
  quad_t      quad_r, quad_nxt;
  logic       fire;
  logic       done;
  logic       sel_right;
  logic       sel_bottom;

  assign fire     = valid_r && out_vtx.ready;
  assign done     = fire && (corner_r == LAST_CORNER);
  assign ld_ready = !valid_r || done;

  // Corner sequencing; a new quad may follow the last vertex directly.
  always_comb begin
    valid_nxt  = valid_r;
    corner_nxt = corner_r;
    quad_nxt   = quad_r;
    if (ld_valid && ld_ready) begin
      valid_nxt  = 1'b1;
      corner_nxt = C_TL0;
      quad_nxt   = ld_quad;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (fire) begin
      corner_nxt = corner_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      corner_r <= C_TL0;
    end else begin
      valid_r  <= valid_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quad_r <= quad_nxt;
  end

  // Which edges of the quad the current vertex sits on.
  always_comb begin
    case (corner_r)
      C_TL0:   begin sel_right = 1'b0; sel_bottom = 1'b0; end
      C_BR0:   begin sel_right = 1'b1; sel_bottom = 1'b1; end
      C_BL:    begin sel_right = 1'b0; sel_bottom = 1'b1; end
      C_TL1:   begin sel_right = 1'b0; sel_bottom = 1'b0; end
      C_TR:    begin sel_right = 1'b1; sel_bottom = 1'b0; end
      C_BR1:   begin sel_right = 1'b1; sel_bottom = 1'b1; end
      default: begin sel_right = 1'b0; sel_bottom = 1'b0; end
    endcase
  end

  assign out_vtx.valid  = valid_r;
  assign out_vtx.pos_x  = sel_right  ? quad_r.xr     : quad_r.xl;
  assign out_vtx.pos_y  = sel_bottom ? quad_r.yb     : quad_r.yt;
  assign out_vtx.tex_u  = sel_right  ? quad_r.right  : quad_r.left;
  assign out_vtx.tex_v  = sel_bottom ? quad_r.bottom : quad_r.top;
  assign out_vtx.corner = corner_r;
  assign out_vtx.last   = (corner_r == LAST_CORNER);

  `GQVB_ASSERT_NEXT(a_corner_step, clk, rst_n, fire && (corner_r != LAST_CORNER), valid_r && (corner_r == $past(corner_r) + 3'd1), "corner did not step after a transfer")
  `GQVB_ASSERT_NEXT(a_load_starts, clk, rst_n, ld_valid && ld_ready, valid_r && (corner_r == C_TL0), "new quad did not start at the first vertex")
  `GQVB_ASSERT_NEXT(a_stall_holds, clk, rst_n, valid_r && !out_vtx.ready, valid_r && $stable(corner_r) && $stable(quad_r), "quad or corner changed while stalled")
  `GQVB_ASSERT_SAME(a_corner_range, clk, rst_n, valid_r, corner_r <= LAST_CORNER, "corner beyond the last vertex")

endmodule

[sv/glyph_quad_vertex_builder_unit.sv]
// Glyph quad vertex builder. Load items write one glyph entry (width scaled by the
// scale register) into the glyph memory; set-pen items place the pen; draw items read
// the glyph, build a quad at the pen and emit six vertices, then advance the pen.
// Load and set-pen items are taken one per cycle unless a draw waits for the emitter.
// A drawn character occupies the single result port for its six vertices; the next
// quad can load as its last vertex leaves. The first vertex comes out after the memory
// read and the emitter's quad register. Spaces and ignored codes produce no vertices.
// There is no clearing pass after reset; a draw may only use entries already loaded.
module glyph_quad_vertex_builder_unit #(
  parameter int GLYPH_COUNT = 95
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gqvb_in_if.sink                          in_item,
  gqvb_out_if.source                       out_vtx,
  input  logic                             cfg_we,
  input  logic [gqvb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gqvb_pkg::WIDTH_W-1:0]     cfg_wdata
);
  import gqvb_pkg::*;

  localparam int         AW       = $clog2(GLYPH_COUNT);
  localparam logic [7:0] COUNT8   = 8'(GLYPH_COUNT);
  localparam logic [8:0] CODE_END = 9'(FIRST_CODE) + 9'(GLYPH_COUNT);

  // Configuration and pen state.
  logic                    vertical_r;
  logic [WIDTH_W-1:0]      scale_r;
  logic signed [POS_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [POS_W-1:0] pen_y_r, pen_y_nxt;
  logic [WIDTH_W-1:0]      space_w_r;

  // Read stage.
  logic                    sr_valid_r, sr_valid_nxt;
  op_t                     sr_op_r;
  logic [WIDTH_W-1:0]      sr_h_r;
  logic signed [POS_W-1:0] sr_x_r;
  logic signed [POS_W-1:0] sr_y_r;
  logic                    sr_done;

  logic                    in_fire;
  logic                    code_ok;
  logic                    load_ok;
  logic [7:0]              code_off;
  logic [AW-1:0]           ld_addr;
  logic [2*WIDTH_W-1:0]    prod;
  logic [WIDTH_W-1:0]      scaled_w;
  logic                    wr_en;
  logic                    rd_en;
  tex_entry_t              wr_tex;
  tex_entry_t              rd_tex;
  logic [WIDTH_W-1:0]      rd_width;
  logic                    emit_ready;
  logic                    emit_valid;
  quad_t                   quad;

  // Item decode.
  assign in_fire  = in_item.valid && in_item.ready;
  assign code_off = in_item.char_code - FIRST_CODE;
  assign code_ok  = (in_item.char_code >= FIRST_CODE) && ({1'b0, in_item.char_code} < CODE_END);
  assign ld_addr  = AW'(in_item.glyph_index);
  assign load_ok  = (in_item.action == ACT_LOAD) && (8'(in_item.glyph_index) < COUNT8);

  // Width scaling: Q8.16 times Q8.16, truncated, saturated.
  assign prod     = {{WIDTH_W{1'b0}}, in_item.raw_width} * {{WIDTH_W{1'b0}}, scale_r};
  assign scaled_w = (|prod[2*WIDTH_W-1:WIDTH_W+16]) ? WIDTH_MAX : prod[WIDTH_W+15:16];

  assign wr_en  = in_fire && load_ok;
  assign wr_tex = '{left: in_item.tex_left, right: in_item.tex_right, top: in_item.tex_top};
  assign rd_en  = in_fire && (in_item.action == ACT_DRAW) && code_ok;

  gqvb_glyph_mem #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .AW          (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (ld_addr),
    .wr_tex   (wr_tex),
    .wr_width (scaled_w),
    .rd_en    (rd_en),
    .rd_addr  (code_off[AW-1:0]),
    .rd_tex   (rd_tex),
    .rd_width (rd_width)
  );

  // The read stage leaves when its work is done; draws wait for the emitter.
  assign emit_valid    = sr_valid_r && (sr_op_r == OP_DRAW);
  assign sr_done       = sr_valid_r && ((sr_op_r != OP_DRAW) || emit_ready);
  assign in_item.ready = !sr_valid_r || sr_done;

  // Quad built from the pen and the glyph read out of memory.
  always_comb begin
    quad.xl     = pen_x_r;
    quad.yt     = pen_y_r;
    quad.xr     = sat_step(pen_x_r, rd_width, 1'b0);
    quad.yb     = sat_step(pen_y_r, sr_h_r, 1'b1);
    quad.left   = rd_tex.left;
    quad.right  = rd_tex.right;
    quad.top    = rd_tex.top;
    quad.bottom = tex_bottom(rd_tex.top);
  end

  // Pen update when the read stage completes.
  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (sr_done) begin
      case (sr_op_r)
        OP_PEN: begin
          pen_x_nxt = sr_x_r;
          pen_y_nxt = sr_y_r;
        end
        OP_SPACE, OP_DRAW: begin
          if (vertical_r) begin
            pen_y_nxt = sat_step(pen_y_r, rd_width, 1'b1);
          end else begin
            pen_x_nxt = sat_step(pen_x_r, rd_width, 1'b0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read stage occupancy: only set-pen items and in-range draws enter.
  always_comb begin
    sr_valid_nxt = sr_valid_r && !sr_done;
    if (in_fire) begin
      sr_valid_nxt = (in_item.action == ACT_PEN) || rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertical_r <= 1'b0;
      scale_r    <= SCALE_RESET;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      sr_valid_r <= 1'b0;
    end else begin
      pen_x_r    <= pen_x_nxt;
      pen_y_r    <= pen_y_nxt;
      sr_valid_r <= sr_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_VERTICAL) begin
          vertical_r <= cfg_wdata[0];
        end else if (cfg_index == CFG_SCALE) begin
          scale_r <= cfg_wdata;
        end
      end
    end
  end

  // Read stage payload, plus a copy of the space glyph width for quad height.
  always_ff @(posedge clk) begin
    if (wr_en && (ld_addr == '0)) begin
      space_w_r <= scaled_w;
    end
    if (in_fire) begin
      sr_op_r <= (in_item.action == ACT_PEN) ? OP_PEN :
                 (code_off == 8'd0)          ? OP_SPACE : OP_DRAW;
      sr_h_r  <= space_w_r;
      sr_x_r  <= in_item.start_x;
      sr_y_r  <= in_item.start_y;
    end
  end

  gqvb_vertex_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (emit_valid),
    .ld_ready (emit_ready),
    .ld_quad  (quad),
    .out_vtx  (out_vtx)
  );

endmodule

[bench/glyph_quad_vertex_builder_unit_tb.sv]
// Self-checking testbench for the glyph quad vertex builder: directed and random text items,
// a predictor of the glyph table and pen, and a vertex-by-vertex scoreboard.
// Depends on gqvb_pkg, the gqvb_in_if and gqvb_out_if interfaces and the block itself.
module glyph_quad_vertex_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gqvb_pkg::*;

  localparam int GLYPH_COUNT = 95;
  // Action code that the block does not use.
  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned DRAIN_LIMIT = 50000;
  localparam int unsigned PHASE_ITEMS = 34;

  typedef struct {
    logic [1:0]               action;
    logic [7:0]               char_code;
    logic [6:0]               glyph_index;
    logic [TEX_W-1:0]         tex_left;
    logic [TEX_W-1:0]         tex_right;
    logic [TEX_W-1:0]         tex_top;
    logic [WIDTH_W-1:0]       raw_width;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;
  } text_item_t;

  typedef struct {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
    logic [2:0]               corner;
    logic                     last;
  } vertex_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0]   cfg_wdata;

  gqvb_in_if  in_item_if ();
  gqvb_out_if out_vtx_if ();

  glyph_quad_vertex_builder_unit #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item_if),
    .out_vtx   (out_vtx_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the block.
  tex_entry_t              glyph_tex_mem [GLYPH_COUNT];
  logic [WIDTH_W-1:0]      glyph_width_mem [GLYPH_COUNT];
  logic signed [POS_W-1:0] pen_pos_x;
  logic signed [POS_W-1:0] pen_pos_y;
  logic                    vert_advance;
  logic [WIDTH_W-1:0]      width_scale;

  text_item_t  pending_items [$];
  vertex_t     predicted_vertices [$];
  bit          glyph_loaded [GLYPH_COUNT];
  int unsigned loaded_glyphs [$];
  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned fail_count;

  text_item_t  item_on_bus;
  int unsigned tx_gap;
  int unsigned rx_stall;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          long_hold_arm;
  bit          long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // Gap lengths: mostly none or short, a few long.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Signed 64-bit value clamped to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[POS_W-1:0];
  endfunction

  task automatic push_vertex(input logic [2:0] corner, input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y, input logic [TEX_W-1:0] u,
                             input logic [TEX_W-1:0] v);
    vertex_t vx;
    vx.pos_x  = x;
    vx.pos_y  = y;
    vx.tex_u  = u;
    vx.tex_v  = v;
    vx.corner = corner;
    vx.last   = (corner == LAST_CORNER);
    predicted_vertices.push_back(vx);
  endtask

  task automatic move_pen(input logic [WIDTH_W-1:0] w);
    if (vert_advance) pen_pos_y = clamp_pos(longint'(pen_pos_y) - longint'(w));
    else pen_pos_x = clamp_pos(longint'(pen_pos_x) + longint'(w));
  endtask

  // Update the glyph table and pen for one accepted item and queue the vertices it yields.
  task automatic predict_text_item(input text_item_t it);
    logic [2*WIDTH_W-1:0]    prod;
    logic [WIDTH_W-1:0]      w;
    logic [WIDTH_W-1:0]      h;
    logic [TEX_W:0]          vsum;
    logic [TEX_W-1:0]        vb;
    logic signed [POS_W-1:0] xl;
    logic signed [POS_W-1:0] xr;
    logic signed [POS_W-1:0] yt;
    logic signed [POS_W-1:0] yb;
    tex_entry_t              t;
    int unsigned             g;
    case (it.action)
      ACT_LOAD: begin
        if (it.glyph_index < GLYPH_COUNT) begin
          glyph_tex_mem[it.glyph_index] = '{left: it.tex_left, right: it.tex_right,
                                            top: it.tex_top};
          prod = {{WIDTH_W{1'b0}}, it.raw_width} * {{WIDTH_W{1'b0}}, width_scale};
          w = (prod[2*WIDTH_W-1:WIDTH_W+16] != 0) ? WIDTH_MAX : prod[WIDTH_W+15:16];
          glyph_width_mem[it.glyph_index] = w;
        end
      end
      ACT_PEN: begin
        pen_pos_x = it.start_x;
        pen_pos_y = it.start_y;
      end
      ACT_DRAW: begin
        if (int'(it.char_code) >= int'(FIRST_CODE) &&
            int'(it.char_code) < int'(FIRST_CODE) + GLYPH_COUNT) begin
          g = it.char_code - FIRST_CODE;
          w = glyph_width_mem[g];
          // A space only moves the pen; every other glyph is a quad of space height.
          if (g != 0) begin
            t    = glyph_tex_mem[g];
            h    = glyph_width_mem[0];
            vsum = {1'b0, t.top} + {1'b0, TEX_V_STEP};
            vb   = (vsum > {1'b0, TEX_MAX}) ? TEX_MAX : vsum[TEX_W-1:0];
            xl   = pen_pos_x;
            yt   = pen_pos_y;
            xr   = clamp_pos(longint'(pen_pos_x) + longint'(w));
            yb   = clamp_pos(longint'(pen_pos_y) - longint'(h));
            push_vertex(C_TL0, xl, yt, t.left, t.top);
            push_vertex(C_BR0, xr, yb, t.right, vb);
            push_vertex(C_BL, xl, yb, t.left, vb);
            push_vertex(C_TL1, xl, yt, t.left, t.top);
            push_vertex(C_TR, xr, yt, t.right, t.top);
            push_vertex(C_BR1, xr, yb, t.right, vb);
          end
          move_pen(w);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Stimulus helpers. Unused fields carry random bits so every input bit toggles.
  function automatic text_item_t noise_fields();
    text_item_t it;
    it.action      = 2'($urandom);
    it.char_code   = 8'($urandom);
    it.glyph_index = 7'($urandom);
    it.tex_left    = TEX_W'($urandom);
    it.tex_right   = TEX_W'($urandom);
    it.tex_top     = TEX_W'($urandom);
    it.raw_width   = WIDTH_W'($urandom);
    it.start_x     = POS_W'($urandom);
    it.start_y     = POS_W'($urandom);
    return it;
  endfunction

  function automatic logic [TEX_W-1:0] rand_tex();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return TEX_W'($urandom_range(0, 65536));
    return (r < 95) ? 17'd0 : 17'd65536;
  endfunction

  function automatic logic [WIDTH_W-1:0] rand_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return WIDTH_W'($urandom_range(0, 24'h040000));
    if (r < 90) return WIDTH_W'($urandom);
    return (r < 95) ? '0 : WIDTH_MAX;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pen();
    if ($urandom_range(0, 4) != 0) begin
      return POS_W'($urandom_range(0, 32'h02000000)) - 32'sh01000000;
    end
    return POS_W'($urandom);
  endfunction

  task automatic queue_item(input text_item_t it);
    pending_items.push_back(it);
    items_queued++;
    if (it.action == ACT_LOAD && it.glyph_index < GLYPH_COUNT &&
        !glyph_loaded[it.glyph_index]) begin
      glyph_loaded[it.glyph_index] = 1'b1;
      loaded_glyphs.push_back(it.glyph_index);
    end
  endtask

  task automatic queue_load(input int unsigned idx, input logic [TEX_W-1:0] l,
                            input logic [TEX_W-1:0] r, input logic [TEX_W-1:0] t,
                            input logic [WIDTH_W-1:0] raw);
    text_item_t it;
    it             = noise_fields();
    it.action      = ACT_LOAD;
    it.glyph_index = 7'(idx);
    it.tex_left    = l;
    it.tex_right   = r;
    it.tex_top     = t;
    it.raw_width   = raw;
    queue_item(it);
  endtask

  task automatic queue_pen(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y);
    text_item_t it;
    it         = noise_fields();
    it.action  = ACT_PEN;
    it.start_x = x;
    it.start_y = y;
    queue_item(it);
  endtask

  task automatic queue_draw(input logic [7:0] code);
    text_item_t it;
    it           = noise_fields();
    it.action    = ACT_DRAW;
    it.char_code = code;
    queue_item(it);
  endtask

  // Mostly runs of characters from loaded glyphs, with reloads, pen moves and some noise.
  task automatic queue_random_text(input int unsigned n_items);
    int unsigned counted;
    int unsigned r;
    int unsigned pick;
    text_item_t  it;
    counted = 0;
    for (int k = 0; k < 4; k++) begin
      queue_load($urandom_range(0, GLYPH_COUNT - 1), rand_tex(), rand_tex(), rand_tex(),
                 rand_width());
      counted++;
    end
    while (counted < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_load($urandom_range(0, GLYPH_COUNT - 1), rand_tex(), rand_tex(), rand_tex(),
                   rand_width());
        counted++;
      end else if (r < 11) begin
        queue_load($urandom_range(GLYPH_COUNT, 127), rand_tex(), rand_tex(), rand_tex(),
                   rand_width());
      end else if (r < 18) begin
        queue_pen(rand_pen(), rand_pen());
        counted++;
      end else if (r < 84) begin
        pick = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
        queue_draw(8'(pick) + FIRST_CODE);
        counted++;
      end else if (r < 90) begin
        if ($urandom_range(0, 1) != 0) queue_draw(8'($urandom_range(0, 31)));
        else queue_draw(8'($urandom_range(127, 255)));
      end else if (r < 94) begin
        it        = noise_fields();
        it.action = ACT_IDLE;
        queue_item(it);
      end else begin
        queue_draw(FIRST_CODE);
        counted++;
      end
    end
  endtask

  // Register writes happen only while the block is idle, so the predictor follows at once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_VERTICAL) vert_advance = data[0];
    else width_scale = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued item is taken and every predicted vertex has arrived.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while ((items_accepted != items_queued || predicted_vertices.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_vertices.size() != 0) begin
      $error("%0d predicted vertices never arrived", predicted_vertices.size());
      fail_count++;
      predicted_vertices.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Input driver: offers queued items, holds each until its transfer, random gaps between.
  always @(posedge clk) begin : item_driver
    if (!rst_n) begin
      in_item_if.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_item_if.valid && in_item_if.ready) begin
        predict_text_item(item_on_bus);
        items_accepted++;
      end
      if (!in_item_if.valid || in_item_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_item_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item_on_bus = pending_items.pop_front();
          in_item_if.action      <= item_on_bus.action;
          in_item_if.char_code   <= item_on_bus.char_code;
          in_item_if.glyph_index <= item_on_bus.glyph_index;
          in_item_if.tex_left    <= item_on_bus.tex_left;
          in_item_if.tex_right   <= item_on_bus.tex_right;
          in_item_if.tex_top     <= item_on_bus.tex_top;
          in_item_if.raw_width   <= item_on_bus.raw_width;
          in_item_if.start_x     <= item_on_bus.start_x;
          in_item_if.start_y     <= item_on_bus.start_y;
          in_item_if.valid       <= 1'b1;
          tx_gap = tx_idle_en ? gap_cycles() : 0;
        end else begin
          in_item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off that backs the block up.
  always @(posedge clk) begin : vertex_ready
    if (!rst_n) begin
      out_vtx_if.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (long_hold_arm && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_stall = LONG_HOLD;
      end else if (rx_stall == 0 && rx_idle_en) begin
        rx_stall = gap_cycles();
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_vtx_if.ready <= 1'b0;
      end else begin
        out_vtx_if.ready <= 1'b1;
      end
    end
  end

  // Vertex checker: each transfer is compared with the oldest prediction.
  always @(posedge clk) begin : vertex_monitor
    vertex_t want;
    if (rst_n && out_vtx_if.valid && out_vtx_if.ready) begin
      if (predicted_vertices.size() == 0) begin
        $error("unexpected vertex: corner %0d at (%0d, %0d)", out_vtx_if.corner,
               out_vtx_if.pos_x, out_vtx_if.pos_y);
        fail_count++;
      end else begin
        want = predicted_vertices.pop_front();
        check_field("pos_x", want.pos_x, out_vtx_if.pos_x);
        check_field("pos_y", want.pos_y, out_vtx_if.pos_y);
        check_field("tex_u", {1'b0, want.tex_u}, {1'b0, out_vtx_if.tex_u});
        check_field("tex_v", {1'b0, want.tex_v}, {1'b0, out_vtx_if.tex_v});
        check_field("corner", {1'b0, want.corner}, {1'b0, out_vtx_if.corner});
        check_field("last", {1'b0, want.last}, {1'b0, out_vtx_if.last});
      end
    end
  end

  // Sequence of test phases.
  initial begin : test_sequence
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    in_item_if.valid       = 1'b0;
    in_item_if.action      = ACT_LOAD;
    in_item_if.char_code   = '0;
    in_item_if.glyph_index = '0;
    in_item_if.tex_left    = '0;
    in_item_if.tex_right   = '0;
    in_item_if.tex_top     = '0;
    in_item_if.raw_width   = '0;
    in_item_if.start_x     = '0;
    in_item_if.start_y     = '0;
    out_vtx_if.ready       = 1'b0;
    pen_pos_x              = '0;
    pen_pos_y              = '0;
    vert_advance           = 1'b0;
    width_scale            = SCALE_RESET;
    items_queued           = 0;
    items_accepted         = 0;
    fail_count             = 0;
    tx_idle_en             = 1'b0;
    rx_idle_en             = 1'b0;
    long_hold_arm          = 1'b0;
    long_hold_done         = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: glyph loads at the extremes, ignored codes and indexes, pen saturation.
    write_reg(CFG_VERTICAL, '0);
    write_reg(CFG_SCALE, SCALE_RESET);
    queue_load(0, 17'd0, 17'd65536, 17'd0, 24'h020000);
    queue_load(33, 17'd0, 17'd65536, 17'd0, 24'h018000);
    queue_load(94, 17'd65536, 17'd0, 17'd65536, 24'hFFFFFF);
    queue_load(127, 17'd65536, 17'd65536, 17'd65536, 24'hFFFFFF);
    queue_pen(32'sd0, 32'sd0);
    queue_draw(8'd65);
    queue_draw(FIRST_CODE);
    queue_draw(8'd126);
    queue_draw(8'd31);
    queue_draw(8'd127);
    queue_draw(8'd255);
    queue_draw(8'd0);
    item_on_bus        = noise_fields();
    item_on_bus.action = ACT_IDLE;
    queue_item(item_on_bus);
    queue_pen(32'sh7FFFFF00, 32'sh80000100);
    queue_draw(8'd126);
    queue_draw(8'd65);
    queue_pen(32'sh80000000, 32'sh7FFFFFFF);
    queue_draw(8'd65);
    wait_drained();

    // Vertical advance with a zero scale, pen near the bottom of the range.
    write_reg(CFG_VERTICAL, 24'd1);
    write_reg(CFG_SCALE, '0);
    queue_load(34, 17'd4096, 17'd8192, 17'd12288, 24'hFFFFFF);
    queue_pen(32'sd0, 32'sh80000010);
    queue_draw(8'd66);
    queue_draw(8'd65);
    wait_drained();

    // Largest scale: width saturation and the smallest non-zero raw width.
    write_reg(CFG_SCALE, WIDTH_MAX);
    queue_load(35, 17'd65536, 17'd65536, 17'd65536, 24'hFFFFFF);
    queue_load(36, 17'd0, 17'd0, 17'd0, 24'd1);
    queue_draw(8'd67);
    queue_draw(8'd68);
    wait_drained();

    // Random text under several settings.
    write_reg(CFG_VERTICAL, '0);
    write_reg(CFG_SCALE, SCALE_RESET);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    queue_random_text(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_VERTICAL, 24'd1);
    write_reg(CFG_SCALE, 24'h008000);
    long_hold_arm = 1'b1;
    queue_random_text(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_VERTICAL, '0);
    write_reg(CFG_SCALE, 24'h020000);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    queue_random_text(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_VERTICAL, 24'd1);
    write_reg(CFG_SCALE, WIDTH_W'($urandom_range(0, 24'hFFFFFF)));
    tx_idle_en = 1'b1;
    queue_random_text(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_VERTICAL, '0);
    write_reg(CFG_SCALE, SCALE_RESET);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    queue_random_text(PHASE_ITEMS);
    wait_drained();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[glyph_quad_vertex_builder_unit.f]
+incdir+sv
sv/gqvb_pkg.sv
sv/gqvb_in_if.sv
sv/gqvb_out_if.sv
sv/gqvb_glyph_mem.sv
sv/gqvb_vertex_emit.sv
sv/glyph_quad_vertex_builder_unit.sv
bench/glyph_quad_vertex_builder_unit_tb.sv
